// File: hw/rtl/ffaa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_pkg
// Shared widths, codes and controller/datapath structs for the first-fit
// arena allocator.
// ----------------------------------------------------------------------------
package ffaa_pkg;

   localparam int MAX_BLOCKS_DEF  = 32;
   localparam int OFFSET_BITS_DEF = 20;

   localparam int ACT_W     = 2;
   localparam int HANDLE_W  = 6;
   localparam int LEN_W     = 21;
   localparam int ADDR_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int END_W     = 22;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_SIZE = 1'b1;

   localparam logic [LEN_W-1:0] ARENA_SIZE_RST = 21'h100000;

   typedef enum logic [ACT_W-1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_REALLOC = 2'd1,
      ACT_FREE    = 2'd2,
      ACT_DEFRAG  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_NO_MEM     = 2'd1,
      ST_BAD_HANDLE = 2'd2,
      ST_TABLE_FULL = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      E_FAIL_FULL,
      E_FAIL_MEM_A,
      E_FAIL_MEM_R,
      E_BAD_R,
      E_BAD_F,
      E_ALLOC_OK,
      E_RESIZE,
      E_MOVE,
      E_FREE,
      E_DEF_MOVE,
      E_DEF_END
   } emit_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_FIND,
      S_CHECK,
      S_FIT,
      S_REMOVE,
      S_INSERT,
      S_DEFRAG,
      S_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic     accept;
      logic     scan_clr;
      logic     step_fit;
      logic     step_def;
      logic     take_slot;
      logic     take_tail;
      logic     take_key;
      logic     do_remove;
      logic     do_insert;
      logic     do_resize;
      logic     def_write;
      logic     emit;
      emit_type emit_code;
   } ctl_cmd_type;

   typedef struct packed {
      logic       taken;
      action_type op;
      logic       full;
      logic       hdl_valid;
      logic       scan_end;
      logic       hdl_match;
      logic       gap_fit;
      logic       tail_fit;
      logic       shrink_ok;
      logic       off_moves;
      logic       out_free;
   } dp_stat_type;

endpackage

// File: hw/rtl/ffaa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_req_if
// Request channel: valid/ready handshake with action, handle and length.
// ----------------------------------------------------------------------------
interface ffaa_req_if import ffaa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    action;
   logic [HANDLE_W-1:0] handle;
   logic [LEN_W-1:0]    length;

   modport source (output valid, output action, output handle, output length, input ready);
   modport sink   (input valid, input action, input handle, input length, output ready);
endinterface

// File: hw/rtl/ffaa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_rsp_if
// Response channel: valid/ready handshake with one allocator result.
// ----------------------------------------------------------------------------
interface ffaa_rsp_if import ffaa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] result_handle;
   logic [ADDR_W-1:0]   address;
   logic [ADDR_W-1:0]   old_address;
   logic [LEN_W-1:0]    block_length;
   logic                moved;
   logic                last;

   modport source (output valid, output status, output result_handle, output address,
                   output old_address, output block_length, output moved, output last,
                   input ready);
   modport sink   (input valid, input status, input result_handle, input address,
                   input old_address, input block_length, input moved, input last,
                   output ready);
endinterface

// File: hw/rtl/ffaa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_ctrl
// Sequencer for the allocator: dispatches each request and steps the
// datapath through table scans, shifts and result emission.
// ----------------------------------------------------------------------------
module ffaa_ctrl import ffaa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   emit_type      ecode_ff, ecode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ecode_ff <= E_DEF_END;
      end else begin
         state_ff <= state_in;
         ecode_ff <= ecode_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ecode_in = ecode_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (stat.taken) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            unique case (stat.op)
               ACT_ALLOC: begin
                  if (stat.full) begin
                     ecode_in = E_FAIL_FULL;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_FIT;
                  end
               end
               ACT_REALLOC: begin
                  if (!stat.hdl_valid) begin
                     ecode_in = E_BAD_R;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_FIND;
                  end
               end
               ACT_FREE: begin
                  if (!stat.hdl_valid) begin
                     ecode_in = E_BAD_F;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_FIND;
                  end
               end
               default: state_in = S_DEFRAG;
            endcase
         end
         S_FIND: begin
            if (stat.hdl_match) begin
               state_in = (stat.op == ACT_FREE) ? S_REMOVE : S_CHECK;
            end else if (stat.scan_end) begin
               ecode_in = (stat.op == ACT_FREE) ? E_BAD_F : E_BAD_R;
               state_in = S_EMIT;
            end
         end
         S_CHECK: begin
            if (stat.shrink_ok) begin
               ecode_in = E_RESIZE;
               state_in = S_EMIT;
            end else begin
               state_in = S_FIT;
            end
         end
         S_FIT: begin
            if ((stat.scan_end && stat.tail_fit) || (!stat.scan_end && stat.gap_fit)) begin
               state_in = (stat.op == ACT_ALLOC) ? S_INSERT : S_REMOVE;
            end else if (stat.scan_end) begin
               ecode_in = (stat.op == ACT_ALLOC) ? E_FAIL_MEM_A : E_FAIL_MEM_R;
               state_in = S_EMIT;
            end
         end
         S_REMOVE: begin
            if (stat.op == ACT_FREE) begin
               ecode_in = E_FREE;
               state_in = S_EMIT;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            ecode_in = (stat.op == ACT_ALLOC) ? E_ALLOC_OK : E_MOVE;
            state_in = S_EMIT;
         end
         S_DEFRAG: begin
            if (stat.scan_end) begin
               ecode_in = E_DEF_END;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.emit_code = ecode_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = 1'b1;
         end
         S_DISPATCH: begin
         end
         S_FIND: begin
            if (stat.hdl_match)      cmd.take_key = 1'b1;
            else if (!stat.scan_end) cmd.step_fit = 1'b1;
         end
         S_CHECK: begin
            if (stat.shrink_ok) cmd.do_resize = 1'b1;
            else                cmd.scan_clr  = 1'b1;
         end
         S_FIT: begin
            if (stat.scan_end)     cmd.take_tail = 1'b1;
            else if (stat.gap_fit) cmd.take_slot = 1'b1;
            else                   cmd.step_fit  = 1'b1;
         end
         S_REMOVE: begin
            cmd.do_remove = 1'b1;
         end
         S_INSERT: begin
            cmd.do_insert = 1'b1;
         end
         S_DEFRAG: begin
            if (!stat.scan_end) begin
               if (!stat.off_moves) begin
                  cmd.step_def = 1'b1;
               end else if (stat.out_free) begin
                  // report the move and pack the entry down
                  cmd.emit      = 1'b1;
                  cmd.emit_code = E_DEF_MOVE;
                  cmd.def_write = 1'b1;
                  cmd.step_def  = 1'b1;
               end
            end
         end
         S_EMIT: begin
            cmd.emit = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hw/rtl/ffaa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_dp
// Allocator datapath: ordered block table, handle bitmap, scan counter,
// fit comparators and the response register.
// ----------------------------------------------------------------------------
module ffaa_dp import ffaa_pkg::*; #(
   parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ffaa_req_if.sink             req,
   ffaa_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   input  ctl_cmd_type          cmd,
   output dp_stat_type          stat
);

   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int OFF_CAP = (OFFSET_BITS < 20) ? OFFSET_BITS : 20;
   localparam int OFF_W   = OFF_CAP + 1;
   localparam int CAP_SH  = (OFFSET_BITS < 21) ? OFFSET_BITS : 21;
   localparam logic [END_W-1:0] ROOM_CAP = END_W'(1) << CAP_SH;

   // block table
   logic [HANDLE_W-1:0] ent_hdl [MAX_BLOCKS];
   logic [OFF_W-1:0]    ent_off [MAX_BLOCKS];
   logic [LEN_W-1:0]    ent_sz  [MAX_BLOCKS];

   logic [ADDR_W-1:0]     base_ff;
   logic [LEN_W-1:0]      size_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [MAX_BLOCKS-1:0] in_use_ff;

   logic [ACT_W-1:0]    act_ff;
   logic [HANDLE_W-1:0] hdl_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [CNT_W-1:0]    idx_ff, pos_ff, kidx_ff;
   logic [END_W-1:0]    acc_ff;
   logic [OFF_W-1:0]    slot_ff, cur_ff;
   logic [LEN_W-1:0]    cursz_ff;
   logic [HANDLE_W-1:0] newh_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] o_status_ff;
   logic [HANDLE_W-1:0] o_handle_ff;
   logic [ADDR_W-1:0]   o_addr_ff, o_old_ff;
   logic [LEN_W-1:0]    o_len_ff;
   logic                o_moved_ff, o_last_ff;

   logic [HANDLE_W-1:0] rd_hdl, hm1, new_hdl;
   logic [OFF_W-1:0]    rd_off;
   logic [LEN_W-1:0]    rd_sz;
   logic [END_W-1:0]    room, rd_end, off_ext, cur_ext, len_ext, size_ext;
   logic                in_range, out_free, is_alloc;
   logic [IDX_W-1:0]    new_idx;
   action_type          op;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] base,
                                                 input logic [END_W-1:0] off);
      return base + ADDR_W'(off);
   endfunction

   assign rd_hdl   = ent_hdl[idx_ff[IDX_W-1:0]];
   assign rd_off   = ent_off[idx_ff[IDX_W-1:0]];
   assign rd_sz    = ent_sz[idx_ff[IDX_W-1:0]];
   assign in_range = idx_ff < count_ff;
   assign off_ext  = END_W'(rd_off);
   assign rd_end   = off_ext + END_W'(rd_sz);
   assign cur_ext  = END_W'(cur_ff);
   assign len_ext  = END_W'(len_ff);
   assign size_ext = END_W'(size_ff);
   assign room     = (size_ext < ROOM_CAP) ? size_ext : ROOM_CAP;
   assign hm1      = hdl_ff - HANDLE_W'(1);
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      op = action_type'(act_ff);
      if (op == ACT_REALLOC && hdl_ff == '0) op = ACT_ALLOC;
   end
   assign is_alloc = (op == ACT_ALLOC);

   // lowest free handle
   always_comb begin
      new_idx = '0;
      for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) new_idx = IDX_W'(i);
      end
   end
   assign new_hdl = HANDLE_W'(new_idx) + HANDLE_W'(1);

   always_comb begin
      stat           = '0;
      stat.taken     = req.valid && req.ready;
      stat.op        = op;
      stat.full      = count_ff >= CNT_W'(MAX_BLOCKS);
      stat.hdl_valid = (hdl_ff != '0) && (hdl_ff <= HANDLE_W'(MAX_BLOCKS))
                       && in_use_ff[hm1[IDX_W-1:0]];
      stat.scan_end  = !in_range;
      stat.hdl_match = in_range && (rd_hdl == hdl_ff);
      stat.gap_fit   = in_range && (idx_ff != '0) && (off_ext >= acc_ff)
                       && ((off_ext - acc_ff) >= len_ext);
      stat.tail_fit  = (acc_ff <= room) && ((room - acc_ff) >= len_ext);
      stat.shrink_ok = (cursz_ff >= len_ff)
                       || (((kidx_ff + CNT_W'(1)) == count_ff) && (cur_ext <= room)
                           && ((room - cur_ext) >= len_ext));
      stat.off_moves = off_ext != acc_ff;
      stat.out_free  = out_free;
   end

   assign req.ready = cmd.accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= ARENA_SIZE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ARENA_BASE: base_ff <= csr_wdata;
            CSR_ARENA_SIZE: size_ff <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // request capture and scan registers
   always_ff @(posedge clock) begin
      if (stat.taken) begin
         act_ff <= req.action;
         hdl_ff <= req.handle;
         len_ff <= req.length;
      end
      if (stat.taken || cmd.scan_clr) begin
         idx_ff <= '0;
         acc_ff <= '0;
      end else if (cmd.step_fit) begin
         idx_ff <= idx_ff + CNT_W'(1);
         acc_ff <= rd_end;
      end else if (cmd.step_def) begin
         idx_ff <= idx_ff + CNT_W'(1);
         acc_ff <= acc_ff + END_W'(rd_sz);
      end
      if (cmd.take_slot) begin
         pos_ff  <= idx_ff;
         slot_ff <= acc_ff[OFF_W-1:0];
      end else if (cmd.take_tail) begin
         pos_ff  <= count_ff;
         slot_ff <= acc_ff[OFF_W-1:0];
      end else if (cmd.do_remove && (kidx_ff < pos_ff)) begin
         // entry below the slot leaves, slot index drops by one
         pos_ff <= pos_ff - CNT_W'(1);
      end
      if (cmd.take_key) begin
         kidx_ff  <= idx_ff;
         cur_ff   <= rd_off;
         cursz_ff <= rd_sz;
      end
      if (cmd.do_insert && is_alloc) newh_ff <= new_hdl;
   end

   // table shifts
   always_ff @(posedge clock) begin
      if (cmd.do_insert) begin
         for (int i = 1; i < MAX_BLOCKS; i++) begin
            if (CNT_W'(i) > pos_ff) begin
               ent_hdl[i] <= ent_hdl[i-1];
               ent_off[i] <= ent_off[i-1];
               ent_sz[i]  <= ent_sz[i-1];
            end
         end
         ent_hdl[pos_ff[IDX_W-1:0]] <= is_alloc ? new_hdl : hdl_ff;
         ent_off[pos_ff[IDX_W-1:0]] <= slot_ff;
         ent_sz[pos_ff[IDX_W-1:0]]  <= len_ff;
      end else if (cmd.do_remove) begin
         for (int i = 0; i < MAX_BLOCKS - 1; i++) begin
            if (CNT_W'(i) >= kidx_ff) begin
               ent_hdl[i] <= ent_hdl[i+1];
               ent_off[i] <= ent_off[i+1];
               ent_sz[i]  <= ent_sz[i+1];
            end
         end
      end else if (cmd.do_resize) begin
         ent_sz[kidx_ff[IDX_W-1:0]] <= len_ff;
      end else if (cmd.def_write) begin
         ent_off[idx_ff[IDX_W-1:0]] <= acc_ff[OFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         in_use_ff <= '0;
      end else if (cmd.do_insert) begin
         count_ff <= count_ff + CNT_W'(1);
         if (is_alloc) in_use_ff[new_idx] <= 1'b1;
      end else if (cmd.do_remove) begin
         count_ff <= count_ff - CNT_W'(1);
         if (op == ACT_FREE) in_use_ff[hm1[IDX_W-1:0]] <= 1'b0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (cmd.emit)   rsp_valid_ff <= 1'b1;
      else if (rsp.ready)  rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         o_status_ff <= ST_OK;
         o_handle_ff <= hdl_ff;
         o_addr_ff   <= '0;
         o_old_ff    <= '0;
         o_len_ff    <= len_ff;
         o_moved_ff  <= 1'b0;
         o_last_ff   <= 1'b1;
         case (cmd.emit_code)
            E_FAIL_FULL: begin
               o_status_ff <= ST_TABLE_FULL;
               o_handle_ff <= '0;
            end
            E_FAIL_MEM_A: begin
               o_status_ff <= ST_NO_MEM;
               o_handle_ff <= '0;
            end
            E_FAIL_MEM_R: begin
               o_status_ff <= ST_NO_MEM;
               o_addr_ff   <= addr_of(base_ff, cur_ext);
            end
            E_BAD_R: begin
               o_status_ff <= ST_BAD_HANDLE;
            end
            E_BAD_F: begin
               o_status_ff <= ST_BAD_HANDLE;
               o_len_ff    <= '0;
            end
            E_ALLOC_OK: begin
               o_handle_ff <= newh_ff;
               o_addr_ff   <= addr_of(base_ff, END_W'(slot_ff));
            end
            E_RESIZE: begin
               o_addr_ff <= addr_of(base_ff, cur_ext);
            end
            E_MOVE: begin
               o_addr_ff  <= addr_of(base_ff, END_W'(slot_ff));
               o_old_ff   <= addr_of(base_ff, cur_ext);
               o_moved_ff <= 1'b1;
            end
            E_FREE: begin
               o_addr_ff <= addr_of(base_ff, cur_ext);
               o_len_ff  <= cursz_ff;
            end
            E_DEF_MOVE: begin
               o_handle_ff <= rd_hdl;
               o_addr_ff   <= addr_of(base_ff, acc_ff);
               o_old_ff    <= addr_of(base_ff, off_ext);
               o_len_ff    <= rd_sz;
               o_moved_ff  <= 1'b1;
               o_last_ff   <= 1'b0;
            end
            default: begin
               o_handle_ff <= '0;
               o_addr_ff   <= addr_of(base_ff, acc_ff);
               o_len_ff    <= acc_ff[LEN_W-1:0];
            end
         endcase
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = o_status_ff;
   assign rsp.result_handle = o_handle_ff;
   assign rsp.address       = o_addr_ff;
   assign rsp.old_address   = o_old_ff;
   assign rsp.block_length  = o_len_ff;
   assign rsp.moved         = o_moved_ff;
   assign rsp.last          = o_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count beyond table depth");

   a_bitmap_count: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> ($countones(in_use_ff) == int'(count_ff)))
      else $error("handle bitmap disagrees with block count");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |-> (count_ff < CNT_W'(MAX_BLOCKS)))
      else $error("insert into a full table");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the table");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("response overwritten before it was taken");

endmodule

// File: hw/rtl/first_fit_arena_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// First-fit arena allocator with realloc, free and defrag over an ordered
// table of live blocks.
// ----------------------------------------------------------------------------
//  channel  direction  handshake      carries
//  req      in         valid/ready    action, handle, length
//  rsp      out        valid/ready    status, result_handle, address,
//                                     old_address, block_length, moved, last
//  csr      in         write enable   csr_index, csr_wdata
//
// One request at a time; the table scan walks one entry per cycle, except that
// a defrag scan pauses on an entry that moves while rsp is stalled.
// Reset (synchronous) empties the table; no clearing pass is needed.
// A stalled rsp holds the response register and pauses the sequencer.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator import ffaa_pkg::*; #(
   parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ffaa_req_if.sink             req,
   ffaa_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   ffaa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   ffaa_dp #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// File: verif/tb_first_fit_arena_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_arena_allocator
// Self-checking bench for the first-fit arena allocator. The bench keeps its
// own copy of the block table and predicts every result of alloc, realloc,
// free and defrag. A driver and a monitor run with random gaps on both
// channels. The run covers several arena settings, including a wrapping
// base, an empty arena and an arena shrunk below the live blocks.
// ----------------------------------------------------------------------------
module tb_first_fit_arena_allocator;
   import ffaa_pkg::*;

   localparam int  NBLK     = MAX_BLOCKS_DEF;
   localparam int  IDLE_LIM = 20000;
   localparam longint OFF_LIM = 64'd1 << OFFSET_BITS_DEF;

   typedef struct {
      action_type          act;
      logic [HANDLE_W-1:0] hdl;
      logic [LEN_W-1:0]    len;
   } request_type;

   typedef struct {
      status_type          st;
      logic [HANDLE_W-1:0] hdl;
      logic [ADDR_W-1:0]   addr;
      logic [ADDR_W-1:0]   old_addr;
      logic [LEN_W-1:0]    len;
      logic                mv;
      logic                lst;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ARENA_BASE;
   logic [ADDR_W-1:0]    csr_wdata = '0;

   ffaa_req_if req ();
   ffaa_rsp_if rsp ();

   first_fit_arena_allocator uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow allocator state
   logic [ADDR_W-1:0]   arena_base_q;
   logic [LEN_W-1:0]    arena_size_q;
   logic [HANDLE_W-1:0] tbl_hdl [NBLK];
   longint              tbl_off [NBLK];
   longint              tbl_sz  [NBLK];
   int                  live_blocks;
   logic [NBLK-1:0]     hdl_live;

   request_type      pending_reqs [$];
   alloc_result_type expected_results [$];
   request_type      cur_req;
   bit            req_busy, req_taken, rsp_taken, quiet;
   int            req_gap, rsp_gap, idle_cycles, errors;
   int            n_reqs, n_results, n_moves, n_full, n_nomem, n_bad;

   initial begin
      req.valid = 1'b0; req.action = ACT_ALLOC; req.handle = '0; req.length = '0;
      rsp.ready = 1'b0;
   end

   function automatic void push_result(status_type st, int h, longint a, longint o,
                                       longint l, bit mv, bit lst);
      alloc_result_type r;
      r.st = st; r.hdl = h[HANDLE_W-1:0]; r.addr = a[ADDR_W-1:0];
      r.old_addr = o[ADDR_W-1:0]; r.len = l[LEN_W-1:0]; r.mv = mv; r.lst = lst;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic longint usable_len();
      return (longint'(arena_size_q) < OFF_LIM) ? longint'(arena_size_q) : OFF_LIM;
   endfunction

   function automatic longint addr_at(longint off);
      return (longint'(arena_base_q) + off) & 64'hFFFF_FFFF;
   endfunction

   function automatic bit find_gap(longint len, output int pos, output longint off);
      longint room, e;
      room = usable_len();
      pos = 0; off = 0;
      for (int i = 0; i + 1 < live_blocks; i++) begin
         e = tbl_off[i] + tbl_sz[i];
         if (tbl_off[i+1] >= e && tbl_off[i+1] - e >= len) begin
            pos = i + 1; off = e;
            return 1'b1;
         end
      end
      if (live_blocks == 0) return len <= room;
      e = tbl_off[live_blocks-1] + tbl_sz[live_blocks-1];
      if (e > room || room - e < len) return 1'b0;
      pos = live_blocks; off = e;
      return 1'b1;
   endfunction

   function automatic void drop_entry(int k);
      for (int i = k; i + 1 < live_blocks; i++) begin
         tbl_hdl[i] = tbl_hdl[i+1]; tbl_off[i] = tbl_off[i+1]; tbl_sz[i] = tbl_sz[i+1];
      end
      live_blocks--;
   endfunction

   function automatic void add_entry(int pos, int h, longint off, longint len);
      for (int i = live_blocks; i > pos; i--) begin
         tbl_hdl[i] = tbl_hdl[i-1]; tbl_off[i] = tbl_off[i-1]; tbl_sz[i] = tbl_sz[i-1];
      end
      tbl_hdl[pos] = h[HANDLE_W-1:0];
      tbl_off[pos] = off & 64'h1F_FFFF;
      tbl_sz[pos]  = len & 64'h1F_FFFF;
      live_blocks++;
   endfunction

   function automatic int table_index(int h);
      if (h == 0 || h > NBLK || !hdl_live[h-1]) return -1;
      for (int i = 0; i < live_blocks; i++)
         if (tbl_hdl[i] == h) return i;
      return -1;
   endfunction

   function automatic void predict_alloc(longint len);
      int pos, h;
      longint off;
      h = 1;
      if (live_blocks >= NBLK) begin
         push_result(ST_TABLE_FULL, 0, 0, 0, len, 0, 1);
         return;
      end
      if (!find_gap(len, pos, off)) begin
         push_result(ST_NO_MEM, 0, 0, 0, len, 0, 1);
         return;
      end
      while (hdl_live[h-1]) h++;
      hdl_live[h-1] = 1'b1;
      add_entry(pos, h, off, len);
      push_result(ST_OK, h, addr_at(off), 0, len, 0, 1);
   endfunction

   function automatic void predict_request(request_type r);
      int k, pos, h;
      longint len, cur, off, nxt;
      h = r.hdl; len = r.len;
      case (r.act)
         ACT_ALLOC: predict_alloc(len);
         ACT_REALLOC: begin
            k = table_index(h);
            if (h == 0) predict_alloc(len);
            else if (k < 0) push_result(ST_BAD_HANDLE, h, 0, 0, len, 0, 1);
            else begin
               cur = tbl_off[k];
               if (tbl_sz[k] >= len || (k + 1 == live_blocks && cur <= usable_len()
                                        && usable_len() - cur >= len)) begin
                  tbl_sz[k] = len;
                  push_result(ST_OK, h, addr_at(cur), 0, len, 0, 1);
               end else if (!find_gap(len, pos, off)) begin
                  push_result(ST_NO_MEM, h, addr_at(cur), 0, len, 0, 1);
               end else begin
                  // keep the handle, move the entry to its new place in order
                  drop_entry(k);
                  if (k < pos) pos--;
                  add_entry(pos, h, off, len);
                  push_result(ST_OK, h, addr_at(off), addr_at(cur), len, 1, 1);
               end
            end
         end
         ACT_FREE: begin
            k = table_index(h);
            if (k < 0) push_result(ST_BAD_HANDLE, h, 0, 0, 0, 0, 1);
            else begin
               off = tbl_off[k]; cur = tbl_sz[k];
               drop_entry(k);
               hdl_live[h-1] = 1'b0;
               push_result(ST_OK, h, addr_at(off), 0, cur, 0, 1);
            end
         end
         default: begin
            nxt = 0;
            for (int i = 0; i < live_blocks; i++) begin
               if (tbl_off[i] != nxt) begin
                  push_result(ST_OK, tbl_hdl[i], addr_at(nxt), addr_at(tbl_off[i]),
                              tbl_sz[i], 1, 0);
                  tbl_off[i] = nxt & 64'h1F_FFFF;
               end
               nxt += tbl_sz[i];
            end
            push_result(ST_OK, 0, addr_at(nxt), 0, nxt, 0, 1);
         end
      endcase
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // request and result handshakes, prediction and checking
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req.valid && req.ready) begin
            predict_request(cur_req);
            req_taken = 1'b1;
            idle_cycles = 0;
            n_reqs++;
         end
         if (rsp.valid && rsp.ready) begin
            alloc_result_type r;
            idle_cycles = 0;
            rsp_taken = 1'b1;
            n_results++;
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction, handle %0d", rsp.result_handle);
               errors++;
            end else begin
               r = expected_results.pop_front();
               check_field("status", r.st, rsp.status);
               check_field("result_handle", r.hdl, rsp.result_handle);
               check_field("address", r.addr, rsp.address);
               check_field("old_address", r.old_addr, rsp.old_address);
               check_field("block_length", r.len, rsp.block_length);
               check_field("moved", r.mv, rsp.moved);
               check_field("last", r.lst, rsp.last);
               if (r.mv) n_moves++;
               if (r.st == ST_TABLE_FULL) n_full++;
               if (r.st == ST_NO_MEM) n_nomem++;
               if (r.st == ST_BAD_HANDLE) n_bad++;
            end
         end
         if (idle_cycles >= IDLE_LIM) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_busy || req_taken) begin
            if (req_taken) begin
               req_busy = 1'b0;
               req_taken = 1'b0;
               req_gap = quiet ? 0 : $urandom_range(0, 3);
            end
            if (req_gap > 0) req_gap--;
            else if (pending_reqs.size() != 0) begin
               cur_req = pending_reqs.pop_front();
               req_busy = 1'b1;
               req.action <= cur_req.act;
               req.handle <= cur_req.hdl;
               req.length <= cur_req.len;
            end
         end
         req.valid <= req_busy;
      end
   end

   // result stall
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_gap = quiet ? 0 : $urandom_range(0, 3);
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp.ready <= 1'b0;
         end else rsp.ready <= 1'b1;
      end
   end

   function automatic void queue_req(action_type a, int h, int len);
      request_type r;
      r.act = a; r.hdl = h[HANDLE_W-1:0]; r.len = len[LEN_W-1:0];
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic void queue_random(int n, int alloc_pct);
      int sel, len;
      action_type a;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < alloc_pct) a = ACT_ALLOC;
         else if (sel < alloc_pct + (100 - alloc_pct) * 2 / 5) a = ACT_REALLOC;
         else if (sel < 95) a = ACT_FREE;
         else a = ACT_DEFRAG;
         sel = $urandom_range(0, 99);
         if (sel < 70) len = $urandom_range(0, 48);
         else if (sel < 94) len = $urandom_range(0, 4096);
         else if (sel < 98) len = $urandom_range(0, 1048576);
         else len = 1048576;
         queue_req(a, $urandom_range(0, NBLK), len);
      end
   endfunction

   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_busy && expected_results.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      if (idx == CSR_ARENA_BASE) arena_base_q = val;
      else arena_size_q = val[LEN_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(logic [ADDR_W-1:0] base, int size, int n, int alloc_pct);
      wait_idle();
      write_csr(CSR_ARENA_BASE, base);
      write_csr(CSR_ARENA_SIZE, size);
      quiet = ($urandom_range(0, 2) == 0);
      queue_random(n, alloc_pct);
   endtask

   initial begin
      arena_base_q = '0; arena_size_q = ARENA_SIZE_RST;
      live_blocks = 0; hdl_live = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero size, whole arena, overflow, bad handles, shrink, grow, move, defrag
      queue_req(ACT_ALLOC, 0, 0);
      queue_req(ACT_ALLOC, 0, 1048576);
      queue_req(ACT_ALLOC, 0, 1);
      queue_req(ACT_FREE, 0, 0);
      queue_req(ACT_FREE, 32, 5);
      queue_req(ACT_REALLOC, 31, 7);
      queue_req(ACT_REALLOC, 2, 16);
      queue_req(ACT_ALLOC, 0, 100);
      queue_req(ACT_REALLOC, 3, 500);
      queue_req(ACT_REALLOC, 1, 8);
      queue_req(ACT_REALLOC, 0, 5);
      queue_req(ACT_FREE, 2, 0);
      queue_req(ACT_DEFRAG, 0, 0);
      queue_req(ACT_REALLOC, 1, 1048576);
      queue_req(ACT_FREE, 1, 0);
      queue_req(ACT_DEFRAG, 0, 0);
      queue_req(ACT_ALLOC, 0, 1048576);

      run_phase(32'hFFFF_FFF0, 4096, 100, 45);
      run_phase($urandom, 1200, 100, 80);     // fill the table
      run_phase(32'h0, 0, 30, 40);            // arena below live blocks
      run_phase(32'hFFFF_FFFF, 1048576, 100, 50);
      run_phase($urandom, $urandom_range(256, 2048), 80, 45);
      wait_idle();

      $display("Requests: %0d, results: %0d, moves: %0d", n_reqs, n_results, n_moves);
      $display("Table full: %0d, no memory: %0d, bad handle: %0d", n_full, n_nomem, n_bad);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
